/* rtl/core/array_list_engine_core_assert.svh */
`ifndef ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
// assertion helpers
`define ALE_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ALE_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/core/ale_pkg.sv */
`timescale 1ns / 1ps
package ale_pkg;
    localparam int LIST_CAPACITY_DEF = 32;
    localparam int ELEM_WIDTH_DEF    = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 3;
    localparam int POS_W = 6;
    localparam int FP_W  = 5;
    localparam int DW    = 32;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_CLEAR  = 3'd0;
    localparam t_op OP_INSERT = 3'd1;
    localparam t_op OP_DELETE = 3'd2;
    localparam t_op OP_SEARCH = 3'd3;
    localparam t_op OP_MINMAX = 3'd4;
    localparam t_op OP_SORT   = 3'd5;
    localparam t_op OP_READ   = 3'd6;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_BADPOS   = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_dn;
        logic load;
        logic sort_even;
        logic sort_odd;
        logic asc;
    } t_cell_ctl;
endpackage

/* rtl/core/ale_if.sv */
`timescale 1ns / 1ps
interface ale_cmd_if;
    import ale_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic signed [DW-1:0] operand_value;
    logic [POS_W-1:0]  position;
    logic              ascending;
    modport source (output valid, opcode, operand_value, position, ascending, input ready);
    modport sink   (input valid, opcode, operand_value, position, ascending, output ready);
endinterface

interface ale_rsp_if;
    import ale_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic signed [DW-1:0] data_out;
    logic signed [DW-1:0] min_out;
    logic [FP_W-1:0]   found_position;
    logic [POS_W-1:0]  item_count;
    modport source (output valid, status, data_out, min_out, found_position, item_count,
                    input ready);
    modport sink   (input valid, status, data_out, min_out, found_position, item_count,
                    output ready);
endinterface

/* rtl/core/ale_cell.sv */
`timescale 1ns / 1ps
module ale_cell
    import ale_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_sel,
    input  logic                  i_up_en,
    input  logic                  i_dn_en,
    input  logic                  i_pair_lo,
    input  logic                  i_pair_hi,
    input  logic [ELEM_WIDTH-1:0] i_load_val,
    input  logic [ELEM_WIDTH-1:0] i_prev,
    input  logic [ELEM_WIDTH-1:0] i_next,
    output logic [ELEM_WIDTH-1:0] o_val
);
    logic [ELEM_WIDTH-1:0] r_val, n_val;
    logic lt_next, gt_prev, swap_lo, swap_hi;

    always_comb begin
        lt_next = $signed(i_next) < $signed(r_val);
        gt_prev = $signed(r_val) < $signed(i_prev);
        // pair lo holds smaller when ascending
        swap_lo = i_ctl.asc ? lt_next : ($signed(r_val) < $signed(i_next));
        swap_hi = i_ctl.asc ? gt_prev : ($signed(i_prev) < $signed(r_val));
        n_val = r_val;
        if (i_ctl.load && i_sel) begin
            n_val = i_load_val;
        end else if (i_ctl.shift_up && i_up_en) begin
            n_val = i_prev;
        end else if (i_ctl.shift_dn && i_dn_en) begin
            n_val = i_next;
        end else if ((i_ctl.sort_even || i_ctl.sort_odd) && i_pair_lo && swap_lo) begin
            n_val = i_next;
        end else if ((i_ctl.sort_even || i_ctl.sort_odd) && i_pair_hi && swap_hi) begin
            n_val = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

/* rtl/core/array_list_engine_core.sv */
`timescale 1ns / 1ps
// order from accept to result beat: clear and rejected commands go straight to the result
// delete and read run a step before the result; insert shifts up, then loads
// search and min/max scan one cell per cycle over the items in the list
// sort: odd-even transposition passes through the cell chain; lists under two items skip them
// one command at a time; next accepted the cycle after the result beat is taken
// reset (synchronous, active low) empties the list; cell contents are not cleared
module array_list_engine_core
    import ale_pkg::*;
#(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
    parameter int ELEM_WIDTH    = ELEM_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ale_cmd_if.sink   i_cmd,
    ale_rsp_if.source o_rsp
);
    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int IW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;

    logic [1:0]  r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_step, n_step;
    t_op     r_op;
    logic    r_asc;
    logic [ELEM_WIDTH-1:0] r_opv;
    t_status r_status, n_status;
    logic [ELEM_WIDTH-1:0] r_data, n_data, r_min, n_min;
    logic [FP_W-1:0] r_fpos, n_fpos;
    logic    r_found, n_found;
    t_cell_ctl ctl;

    logic [ELEM_WIDTH-1:0] vals [LIST_CAPACITY];
    logic [ELEM_WIDTH-1:0] cur;
    logic [XW-1:0] cin_pos;
    logic [XW-1:0] cnt_x;
    logic accept;

    assign accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_st == S_IDLE);
    assign cin_pos = XW'(i_cmd.position);
    assign cnt_x = XW'(r_cnt);
    assign cur = vals[r_step[IW-1:0]];

    genvar g;
    generate
        for (g = 0; g < LIST_CAPACITY; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] prv, nxt;
            logic pl, ph;
            assign prv = (g == 0) ? vals[0] : vals[(g == 0) ? 0 : g - 1];
            assign nxt = (g == LIST_CAPACITY - 1) ? vals[g]
                         : vals[(g == LIST_CAPACITY - 1) ? g : g + 1];
            // pair (g,g+1) active on even steps if g even, odd steps if g odd
            assign pl = (g < LIST_CAPACITY - 1) && ((g + 1) < r_cnt)
                        && ((g % 2 == 0) ? ctl.sort_even : ctl.sort_odd);
            assign ph = (g > 0) && (g < r_cnt)
                        && (((g - 1) % 2 == 0) ? ctl.sort_even : ctl.sort_odd);
            ale_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_sel      (CW'(g) == r_pos),
                .i_up_en    ((CW'(g) > r_pos) && (CW'(g) <= r_cnt)),
                .i_dn_en    ((CW'(g) >= r_pos) && (CW'(g) + 1'b1 < r_cnt)),
                .i_pair_lo  (pl),
                .i_pair_hi  (ph),
                .i_load_val (r_opv),
                .i_prev     (prv),
                .i_next     (nxt),
                .o_val      (vals[g])
            );
        end
    endgenerate

    always_comb begin
        ctl = '0;
        ctl.asc = r_asc;
        if (r_st == S_RUN) begin
            unique case (r_op)
                OP_INSERT: begin
                    ctl.shift_up = (r_step == '0);
                    ctl.load     = (r_step != '0);
                end
                OP_DELETE: ctl.shift_dn = 1'b1;
                OP_SORT: begin
                    ctl.sort_even = !r_step[0];
                    ctl.sort_odd  = r_step[0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_step = r_step; n_status = r_status;
        n_data = r_data; n_min = r_min; n_fpos = r_fpos; n_found = r_found;
        unique case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_step = '0; n_status = ST_OK; n_data = '0; n_min = '0;
                    n_fpos = '0; n_found = 1'b0; n_st = S_RUN;
                    unique case (i_cmd.opcode)
                        OP_CLEAR: begin n_cnt = '0; n_st = S_OUT; end
                        OP_INSERT: begin
                            if (r_cnt >= CW'(LIST_CAPACITY)) begin
                                n_status = ST_FULL; n_st = S_OUT;
                            end else if (cin_pos > cnt_x) begin
                                n_status = ST_BADPOS; n_st = S_OUT;
                            end
                        end
                        OP_DELETE, OP_READ: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY; n_st = S_OUT;
                            end else if (cin_pos >= cnt_x) begin
                                n_status = ST_BADPOS; n_st = S_OUT;
                            end
                        end
                        OP_SEARCH: begin
                            n_status = ST_NOTFOUND;
                            if (r_cnt == '0) n_st = S_OUT;
                        end
                        OP_MINMAX: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY; n_st = S_OUT;
                            end
                        end
                        OP_SORT: if (r_cnt < CW'(2)) n_st = S_OUT;
                        default: n_st = S_OUT;
                    endcase
                end
            end
            S_RUN: begin
                n_step = r_step + 1'b1;
                unique case (r_op)
                    OP_INSERT: if (r_step != '0) begin
                        n_cnt = r_cnt + 1'b1; n_st = S_OUT;
                    end
                    OP_DELETE: begin
                        n_data = vals[r_pos[IW-1:0]];
                        n_cnt = r_cnt - 1'b1; n_st = S_OUT;
                    end
                    OP_READ: begin
                        n_data = vals[r_pos[IW-1:0]]; n_st = S_OUT;
                    end
                    OP_SEARCH: begin
                        if (!r_found && cur == r_opv) begin
                            n_found = 1'b1; n_status = ST_OK;
                            n_fpos = FP_W'(r_step);
                        end
                        if (r_step + 1'b1 >= r_cnt) n_st = S_OUT;
                    end
                    OP_MINMAX: begin
                        if (r_step == '0 || $signed(cur) > $signed(r_data)) n_data = cur;
                        if (r_step == '0 || $signed(cur) < $signed(r_min)) n_min = cur;
                        if (r_step + 1'b1 >= r_cnt) n_st = S_OUT;
                    end
                    OP_SORT: if (r_step + 1'b1 >= r_cnt) n_st = S_OUT;
                    default: n_st = S_OUT;
                endcase
            end
            S_OUT: if (o_rsp.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
        end
        r_step <= n_step; r_status <= n_status; r_data <= n_data; r_min <= n_min;
        r_fpos <= n_fpos; r_found <= n_found;
        if (accept) begin
            r_op <= i_cmd.opcode;
            r_asc <= i_cmd.ascending;
            r_opv <= ELEM_WIDTH'(i_cmd.operand_value);
            r_pos <= CW'(i_cmd.position);
        end
    end

    assign o_rsp.valid = (r_st == S_OUT);
    assign o_rsp.status = r_status;
    assign o_rsp.data_out = DW'($signed(r_data));
    assign o_rsp.min_out = DW'($signed(r_min));
    assign o_rsp.found_position = r_fpos;
    assign o_rsp.item_count = POS_W'(r_cnt);
endmodule

/* rtl/core/ale_checker.sv */
`timescale 1ns / 1ps
`include "array_list_engine_core_assert.svh"
module ale_checker
    import ale_pkg::*;
#(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_valid,
    input logic i_cmd_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic [ST_W-1:0] i_status,
    input logic [POS_W-1:0] i_count
);
    `ALE_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, i_rsp_valid, !i_cmd_ready)
    `ALE_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `ALE_ASSERT_IMP(a_status_ok, i_clk, i_rst_n, i_rsp_valid, i_status <= ST_NOTFOUND)
    `ALE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, i_rsp_valid, i_count <= POS_W'(LIST_CAPACITY))
endmodule

bind array_list_engine_core ale_checker #(.LIST_CAPACITY(LIST_CAPACITY)) u_ale_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_count     (o_rsp.item_count)
);
